@@ hw/rtl/ic_pkg.sv @@
// Shared types and constants for the inversion counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ic_pkg;

    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 19;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // token control moving down the cell chain
    typedef struct packed {
        logic valid;
        logic last;
        logic placed;
    } ic_tok_t;

endpackage

`default_nettype wire

@@ hw/rtl/ic_cell.sv @@
// One chain cell: holds one stored value, counts greater-than for passing tokens.
// Depends on ic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ic_cell #(
    parameter int CNT_W = 11
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire ic_pkg::ic_tok_t               tok_in,
    input  wire logic signed [ic_pkg::VALUE_W-1:0] val_in,
    input  wire logic [CNT_W-1:0]              cnt_in,
    output ic_pkg::ic_tok_t                    tok_out,
    output logic signed [ic_pkg::VALUE_W-1:0]  val_out,
    output logic [CNT_W-1:0]                   cnt_out
);
    import ic_pkg::*;

    logic signed [VALUE_W-1:0] stored_reg, stored_next;
    logic                      occ_reg, occ_next;
    ic_tok_t                   tok_reg, tok_next;
    logic signed [VALUE_W-1:0] val_reg;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      gt;

    assign gt = tok_in.valid && occ_reg && (stored_reg > val_in);

    always_comb begin
        stored_next = stored_reg;
        occ_next    = occ_reg;
        tok_next    = tok_in;
        cnt_next    = cnt_in + CNT_W'(gt);
        if (tok_in.valid) begin
            if (!occ_reg && !tok_in.placed) begin
                stored_next     = val_in;
                occ_next        = 1'b1;
                tok_next.placed = 1'b1;
            end
            // end of sequence clears the cell behind the token
            if (tok_in.last) begin
                occ_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
            tok_reg <= '0;
        end else if (en) begin
            occ_reg <= occ_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stored_reg <= stored_next;
            val_reg    <= val_in;
            cnt_reg    <= cnt_next;
        end
    end

    assign tok_out = tok_reg;
    assign val_out = val_reg;
    assign cnt_out = cnt_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ic_accum.sv @@
// End of chain: running total with saturation, overflow flag, result register.
// Depends on ic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ic_accum #(
    parameter int CNT_W = 11
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire ic_pkg::ic_tok_t             tok_in,
    input  wire logic [CNT_W-1:0]            cnt_in,
    output logic                             advance,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [ic_pkg::TOTAL_W-1:0]       res_count,
    output logic                             res_ovf
);
    import ic_pkg::*;

    localparam int SUM_W = ((CNT_W > TOTAL_W) ? CNT_W : TOTAL_W) + 1;

    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               ovf_reg, ovf_next;
    logic               mvalid_reg, mvalid_next;
    logic [TOTAL_W-1:0] mcount_reg, mcount_next;
    logic               movf_reg, movf_next;
    logic [SUM_W-1:0]   sum;
    logic [TOTAL_W-1:0] t_new;
    logic               o_new;

    assign advance = !(mvalid_reg && !m_tready && tok_in.valid && tok_in.last);
    assign sum     = SUM_W'(total_reg) + SUM_W'(cnt_in);

    always_comb begin
        if (tok_in.placed) begin
            if (sum > SUM_W'(TOTAL_MAX)) begin
                t_new = TOTAL_MAX;
                o_new = 1'b1;
            end else begin
                t_new = sum[TOTAL_W-1:0];
                o_new = ovf_reg;
            end
        end else begin
            // beyond capacity: not counted
            t_new = total_reg;
            o_new = 1'b1;
        end

        total_next  = total_reg;
        ovf_next    = ovf_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mcount_next = mcount_reg;
        movf_next   = movf_reg;
        if (advance && tok_in.valid) begin
            if (tok_in.last) begin
                mvalid_next = 1'b1;
                mcount_next = t_new;
                movf_next   = o_new;
                total_next  = '0;
                ovf_next    = 1'b0;
            end else begin
                total_next = t_new;
                ovf_next   = o_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= '0;
            ovf_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            total_reg  <= total_next;
            ovf_reg    <= ovf_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcount_reg <= mcount_next;
        movf_reg   <= movf_next;
    end

    assign m_tvalid  = mvalid_reg;
    assign res_count = mcount_reg;
    assign res_ovf   = movf_reg;

endmodule

`default_nettype wire

@@ hw/rtl/inversion_counter_top.sv @@
// Inversion counter: a chain of MAX_ITEMS cells, one stored value each, plus accumulator.
// An accepted last transaction passes each cell register, then the accumulator's result register, to m_tvalid.
// Throughput: one transaction per cycle while the chain is not stalled; each token moves one cell per cycle.
// The chain stalls only while a finished result waits and another one reaches its end.
// Reset clears cell occupancy, totals and output valid; stored values are not reset.
// Depends on ic_pkg, ic_cell, ic_accum.
`timescale 1ns / 1ps
`default_nettype none

module inversion_counter_top #(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tlast,   // is_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [18:0] inversion_count, [23:19] zero
    output logic [0:0]       m_tuser    // [0] overflow
);
    import ic_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    ic_tok_t                   tok  [MAX_ITEMS+1];
    logic signed [VALUE_W-1:0] vals [MAX_ITEMS+1];
    logic [CNT_W-1:0]          cnts [MAX_ITEMS+1];
    logic                      advance;
    logic [TOTAL_W-1:0]        res_count;
    logic                      res_ovf;

    assign s_tready = advance;

    assign tok[0]  = '{valid: s_tvalid && advance, last: s_tlast, placed: 1'b0};
    assign vals[0] = s_tdata;
    assign cnts[0] = '0;

    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        ic_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (advance),
            .tok_in  (tok[k]),
            .val_in  (vals[k]),
            .cnt_in  (cnts[k]),
            .tok_out (tok[k+1]),
            .val_out (vals[k+1]),
            .cnt_out (cnts[k+1])
        );
    end

    ic_accum #(
        .CNT_W (CNT_W)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_in    (tok[MAX_ITEMS]),
        .cnt_in    (cnts[MAX_ITEMS]),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res_count (res_count),
        .res_ovf   (res_ovf)
    );

    assign m_tdata = {5'b0, res_count};
    assign m_tuser = res_ovf;

endmodule

`default_nettype wire
